// ===== hw/rtl/sti_pkg.sv =====
// Shared types and operation codes for the sorted table insert block.
package sti_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_BY_KEY = 2'd0;
    localparam kind_t KIND_UNIQUE = 2'd1;
    localparam kind_t KIND_AT_POS = 2'd2;

endpackage

// ===== hw/rtl/sti_req_if.sv =====
// Request channel: one insert item with valid/ready handshake.
interface sti_req_if #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int POS_WIDTH   = 5
);
    import sti_pkg::*;

    logic                   valid;
    logic                   ready;
    kind_t                  kind;
    logic [KEY_WIDTH-1:0]   new_key;
    logic [VALUE_WIDTH-1:0] new_value;
    logic [POS_WIDTH-1:0]   position;

    modport source (output valid, output kind, output new_key, output new_value,
                    output position, input ready);
    modport sink   (input valid, input kind, input new_key, input new_value,
                    input position, output ready);
endinterface

// ===== hw/rtl/sti_res_if.sv =====
// Result channel: one outcome item per request with valid/ready handshake.
interface sti_res_if #(
    parameter int IDX_WIDTH = 4,
    parameter int CNT_WIDTH = 5
);
    logic                 valid;
    logic                 ready;
    logic [IDX_WIDTH-1:0] placed_at;
    logic                 duplicate;
    logic                 full_res;
    logic [CNT_WIDTH-1:0] entries_now;

    modport source (output valid, output placed_at, output duplicate, output full_res,
                    output entries_now, input ready);
    modport sink   (input valid, input placed_at, input duplicate, input full_res,
                    input entries_now, output ready);
endinterface

// ===== hw/rtl/sorted_table_insert.sv =====
// Sorted key/value table with insert by key, unique insert and insert at position.
//
// Usage:
//   req carries one insert item (kind, new_key, new_value, position); res returns
//   one result item (placed_at, duplicate, full_res, entries_now) for every item.
//   Both channels transfer on a clock edge with valid and ready high.
//   Items are handled one at a time. Keys and values live in a single RAM with
//   one write and one read port, and each item walks it one entry per cycle:
//     insert by key / unique insert: a lower-bound scan up to the first key at or
//       above new_key (or past the count on a miss), then a shift of the entries
//       from placed_at upward, or a single write when the pair is appended.
//     insert at position: the same shift only.
//   Unused-kind items and full items of the other two kinds skip the scan and the
//   shift; a unique insert on a full table still scans before it reports.
//   The result register lets req accept the next item while a result waits; a
//   stalled res holds the finished result and the block waits before handing over.
//   Reset empties the table (count zero); the RAM needs no clearing since only
//   entries below the count are ever read.
module sorted_table_insert #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    sti_req_if.sink   req,
    sti_res_if.source res
);
    import sti_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_WIDTH + VALUE_WIDTH;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [CW-1:0]          pend_idx_reg, pend_idx_next;
    kind_t                  kind_reg, kind_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [CW-1:0]          at_reg, at_next;
    logic                   dup_reg, dup_next;
    logic                   full_reg, full_next;

    logic                   out_valid_reg, out_valid_next;
    logic [AW-1:0]          out_at_reg;
    logic                   out_dup_reg;
    logic                   out_full_reg;
    logic [CW-1:0]          out_cnt_reg;
    logic                   out_load;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [EW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [EW-1:0]          ram_rdata;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [CW-1:0]          src_idx;
    logic                   is_full;

    sti_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[EW-1:VALUE_WIDTH];
    assign src_idx = idx_reg - CW'(1);
    assign is_full = (count_reg == FULL_COUNT);

    assign req.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.placed_at   = out_at_reg;
    assign res.duplicate   = out_dup_reg;
    assign res.full_res    = out_full_reg;
    assign res.entries_now = out_cnt_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        at_next       = at_reg;
        dup_next      = dup_reg;
        full_next     = full_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = {key_reg, value_reg};
        ram_raddr     = '0;
        out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    key_next   = req.new_key;
                    value_next = req.new_value;
                    dup_next   = 1'b0;
                    full_next  = 1'b0;
                    at_next    = '0;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    case (req.kind)
                        KIND_AT_POS:
                        begin
                            if (is_full)
                            begin
                                full_next  = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                at_next    = (req.position > count_reg) ? count_reg
                                                                        : req.position;
                                idx_next   = count_reg;
                                state_next = S_SHIFT;
                            end
                        end
                        KIND_BY_KEY:
                        begin
                            if (is_full)
                            begin
                                full_next  = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        KIND_UNIQUE:
                        begin
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (pend_reg && (rd_key >= key_reg))
                begin
                    pend_next = 1'b0;
                    at_next   = pend_idx_reg;
                    if ((kind_reg == KIND_UNIQUE) && (rd_key == key_reg))
                    begin
                        dup_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (is_full)
                    begin
                        full_next  = 1'b1;
                        at_next    = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_reg < count_reg)
                begin
                    ram_raddr     = idx_reg[AW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (is_full)
                    begin
                        full_next  = 1'b1;
                        at_next    = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        at_next    = count_reg;
                        idx_next   = count_reg;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // entry read last cycle lands one slot up
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (idx_reg > at_reg)
                begin
                    ram_raddr     = src_idx[AW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = src_idx;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = at_reg[AW-1:0];
                        ram_wdata  = {key_reg, value_reg};
                        count_next = count_reg + CW'(1);
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        at_reg       <= at_next;
        dup_reg      <= dup_next;
        full_reg     <= full_next;
        if (out_load)
        begin
            out_at_reg   <= at_reg[AW-1:0];
            out_dup_reg  <= dup_reg;
            out_full_reg <= full_reg;
            out_cnt_reg  <= count_reg;
        end
    end
endmodule

// ===== hw/rtl/sti_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module sti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/sti_chk.sv =====
// Port-level assertions for the sorted table insert block, bound to the top level.
module sti_chk #(
    parameter int DEPTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [$clog2(DEPTH)-1:0]     res_placed_at,
    input logic                         res_duplicate,
    input logic                         res_full_res,
    input logic [$clog2(DEPTH+1)-1:0]   res_entries_now
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // a stalled result item holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(res_placed_at) && $stable(res_duplicate) &&
             $stable(res_full_res) && $stable(res_entries_now)))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while previous item in flight");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_duplicate && res_full_res))
        else $error("duplicate and full both set");

    a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_full_res) |->
            ((res_entries_now == FULL_COUNT) && (res_placed_at == '0)))
        else $error("full result with wrong count or position");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_entries_now <= FULL_COUNT))
        else $error("entry count above depth");
endmodule

bind sorted_table_insert sti_chk #(
    .DEPTH (DEPTH)
) u_sti_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_placed_at   (res.placed_at),
    .res_duplicate   (res.duplicate),
    .res_full_res    (res.full_res),
    .res_entries_now (res.entries_now)
);

// ===== tb/tb_sorted_table_insert.sv =====
// Self-checking testbench for the sorted key/value table insert block.
`timescale 1ns / 1ps

module tb_sorted_table_insert;
    import sti_pkg::*;

    localparam int          TABLE_DEPTH  = 16;
    localparam kind_t       KIND_UNUSED  = 2'd3;
    localparam int          RANDOM_ITEMS = 900;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [3:0] placed_at;
        logic       duplicate;
        logic       full_res;
        logic [4:0] entries_now;
    } outcome_t;

    class table_tracker;
        logic [31:0] keys [TABLE_DEPTH];
        int unsigned count;
        outcome_t    pending_outcomes [$];
        int unsigned errors;
        int unsigned results_seen;

        function new();
            count        = 0;
            errors       = 0;
            results_seen = 0;
        endfunction

        task report(string what);
            $display("%0t: mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void note_insert(kind_t kind, logic [31:0] key, logic [4:0] pos);
            outcome_t    o;
            int unsigned at;
            bit          dup;
            bit          full;
            at   = 0;
            dup  = 0;
            full = 0;
            if (kind != KIND_UNUSED)
            begin
                if (kind == KIND_AT_POS)
                begin
                    at = (pos > count) ? count : pos;
                end
                else
                begin
                    at = count;
                    for (int i = 0; i < count; i++)
                    begin
                        if (keys[i] >= key)
                        begin
                            at = i;
                            break;
                        end
                    end
                    dup = (kind == KIND_UNIQUE) && (at < count) && (keys[at] == key);
                end
                if (!dup)
                begin
                    if (count >= TABLE_DEPTH)
                    begin
                        full = 1;
                        at   = 0;
                    end
                    else
                    begin
                        for (int i = count; i > at; i--)
                            keys[i] = keys[i-1];
                        keys[at] = key;
                        count++;
                    end
                end
            end
            o.placed_at   = at[3:0];
            o.duplicate   = dup;
            o.full_res    = full;
            o.entries_now = count[4:0];
            pending_outcomes.push_back(o);
        endfunction

        task check_outcome(outcome_t got);
            outcome_t want;
            results_seen++;
            if (pending_outcomes.size() == 0)
            begin
                report("result item with none expected");
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.placed_at !== want.placed_at)
                report($sformatf("placed_at %0d, expected %0d",
                                 got.placed_at, want.placed_at));
            if (got.duplicate !== want.duplicate)
                report($sformatf("duplicate %b, expected %b",
                                 got.duplicate, want.duplicate));
            if (got.full_res !== want.full_res)
                report($sformatf("full_res %b, expected %b",
                                 got.full_res, want.full_res));
            if (got.entries_now !== want.entries_now)
                report($sformatf("entries_now %0d, expected %0d",
                                 got.entries_now, want.entries_now));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int unsigned cycle_count;
    bit          quiet;

    table_tracker tracker;

    sti_req_if req_ch ();
    sti_res_if res_ch ();

    sorted_table_insert u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always #4 clk = ~clk;

    task automatic send_item(kind_t kind, logic [31:0] key, logic [31:0] value,
                             logic [4:0] pos);
        while (!quiet && $urandom_range(99) < 12)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.new_key   <= key;
        req_ch.new_value <= value;
        req_ch.position  <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_insert(kind, key, pos);
    endtask

    function automatic logic [31:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40 && tracker.count > 0)
            return tracker.keys[$urandom_range(tracker.count - 1)];
        if (r < 44)
            return 32'h0000_0000;
        if (r < 48)
            return 32'hFFFF_FFFF;
        if (r < 50)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return KIND_UNUSED;
        if (r < 40)
            return KIND_BY_KEY;
        if (r < 75)
            return KIND_UNIQUE;
        return KIND_AT_POS;
    endfunction

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_table_insert test failed");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned hold_left;
        bit          held;
        outcome_t    got;
        hold_left = 0;
        held      = 0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.placed_at   = res_ch.placed_at;
                got.duplicate   = res_ch.duplicate;
                got.full_res    = res_ch.full_res;
                got.entries_now = res_ch.entries_now;
                tracker.check_outcome(got);
            end
            // long receiver stall so the block backs up onto its input
            if (!held && tracker.results_seen == 40)
            begin
                held      = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (quiet)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(99) >= 12);
        end
    end

    initial
    begin : stimulus
        tracker = new();
        quiet   = 0;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_BY_KEY;
        req_ch.new_key   <= '0;
        req_ch.new_value <= '0;
        req_ch.position  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, duplicates, saturated positions, disorder, full table
        send_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_item(KIND_UNIQUE, 32'h0000_0000, 32'h0000_0000, 5'd0);
        send_item(KIND_BY_KEY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
        send_item(KIND_UNIQUE, 32'hFFFF_FFFF, 32'h1234_5678, 5'd0);
        send_item(KIND_UNIQUE, 32'h0000_0000, 32'h8765_4321, 5'd0);
        send_item(KIND_BY_KEY, 32'h0000_0000, 32'hAAAA_5555, 5'd31);
        send_item(KIND_AT_POS, 32'h1234_5678, 32'h5555_AAAA, 5'd31);
        send_item(KIND_AT_POS, 32'h8000_0000, 32'h0F0F_F0F0, 5'd0);
        send_item(KIND_BY_KEY, 32'h7FFF_FFFF, 32'hF0F0_0F0F, 5'd0);
        send_item(KIND_AT_POS, 32'h0000_0001, 32'h0000_0001, 5'd16);
        send_item(KIND_UNIQUE, 32'h1234_5678, 32'h0000_0002, 5'd0);
        send_item(KIND_AT_POS, 32'hFFFF_FFFE, 32'h0000_0003, tracker.count[4:0]);
        while (tracker.count < TABLE_DEPTH)
            send_item(KIND_BY_KEY, $urandom, $urandom, 5'($urandom_range(31)));
        send_item(KIND_BY_KEY, 32'h4000_0000, 32'hFFFF_FFFF, 5'd0);
        send_item(KIND_UNIQUE, tracker.keys[TABLE_DEPTH-1], 32'h0, 5'd0);
        send_item(KIND_UNIQUE, 32'h5A5A_A5A5, 32'h0, 5'd0);
        send_item(KIND_AT_POS, 32'h0000_0002, 32'h0, 5'd5);
        send_item(KIND_UNUSED, 32'h0, 32'h0, 5'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 300 && n < 500);
            send_item(pick_kind(), pick_key(), $urandom, 5'($urandom_range(31)));
        end
        quiet = 0;
        req_ch.valid <= 1'b0;

        while (tracker.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending_outcomes.size() != 0)
            tracker.report("expected result items never arrived");

        if (tracker.errors == 0)
            $display("sorted_table_insert test passed");
        else
            $display("sorted_table_insert test failed");
        $finish;
    end

endmodule
